// ===== sv/rbst_pkg.sv =====
// Package for the ray versus box slab test: widths, types and constants.
// Used by every module in the sv folder; depends on nothing.
`default_nettype none
package rbst_pkg;
	localparam int COORD_WIDTH = 32;
	localparam int FRAC_BITS   = 16;
	localparam int NUM_AXES    = 3;
	localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
	localparam int QUOT_WIDTH  = COORD_WIDTH + FRAC_BITS + 1;
	localparam int T_WIDTH     = QUOT_WIDTH + 1;
	localparam int DIV_STEPS   = QUOT_WIDTH;

	typedef logic signed [COORD_WIDTH-1:0] coord_t;
	typedef logic signed [T_WIDTH-1:0] tval_t;

	typedef struct packed {
		logic  bounded;
		logic  miss;
		tval_t near_t;
		tval_t far_t;
	} slab_t;
endpackage
`default_nettype wire

// ===== sv/ray_box_slab_test_top.sv =====
// Top level of the ray versus axis-aligned box slab test.
// Depends on rbst_pkg, rbst_lane and rbst_merge.
//  channel | ports                                   | handshake
//  input   | origin_*, dir_*, box_min_*, box_max_*   | start while busy low
//  result  | hit                                     | done strobe, one cycle
// One item may be started every cycle; busy is always low.
// Items pass the lane input, divider and slab registers, then the merge registers.
// Reset clears the valid pipeline and the slab registers; results cannot be stalled.
`default_nettype none
module ray_box_slab_test_top (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output logic                  busy,
	input  wire rbst_pkg::coord_t origin_x,
	input  wire rbst_pkg::coord_t origin_y,
	input  wire rbst_pkg::coord_t origin_z,
	input  wire rbst_pkg::coord_t dir_x,
	input  wire rbst_pkg::coord_t dir_y,
	input  wire rbst_pkg::coord_t dir_z,
	input  wire rbst_pkg::coord_t box_min_x,
	input  wire rbst_pkg::coord_t box_min_y,
	input  wire rbst_pkg::coord_t box_min_z,
	input  wire rbst_pkg::coord_t box_max_x,
	input  wire rbst_pkg::coord_t box_max_y,
	input  wire rbst_pkg::coord_t box_max_z,
	output logic                  done,
	output logic                  hit
);
	localparam int LAT = rbst_pkg::DIV_STEPS + 4;

	rbst_pkg::slab_t sx, sy, sz;
	logic [LAT-1:0] vld_q;

	assign busy = 1'b0;

	rbst_lane u_lane_x (.clk, .arst_n, .origin(origin_x), .dir(dir_x),
		.bmin(box_min_x), .bmax(box_max_x), .slab(sx));
	rbst_lane u_lane_y (.clk, .arst_n, .origin(origin_y), .dir(dir_y),
		.bmin(box_min_y), .bmax(box_max_y), .slab(sy));
	rbst_lane u_lane_z (.clk, .arst_n, .origin(origin_z), .dir(dir_z),
		.bmin(box_min_z), .bmax(box_max_z), .slab(sz));
	rbst_merge u_merge (.clk, .sx, .sy, .sz, .hit);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_q <= '0;
		else
			vld_q <= {vld_q[LAT-2:0], start && !busy};
	end
	assign done = vld_q[LAT-1];

	a_done_follows_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(vld_q[LAT-2])) else $error("done without a started item");
	a_never_busy: assert property (@(posedge clk) !busy) else $error("busy raised");
	a_hit_known: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !$isunknown(hit)) else $error("hit unknown on done");
endmodule
`default_nettype wire

// ===== sv/rbst_div.sv =====
// Pipelined restoring divider giving trunc((num << FRAC_BITS) / den), one quotient bit a stage.
// Depends on rbst_pkg. Takes a new division every cycle.
`default_nettype none
module rbst_div (
	input  wire logic                            clk,
	input  wire logic [rbst_pkg::DIFF_WIDTH-1:0] num_mag,
	input  wire logic [rbst_pkg::COORD_WIDTH-1:0] den_mag,
	output logic      [rbst_pkg::QUOT_WIDTH-1:0] quot
);
	localparam int N = rbst_pkg::DIV_STEPS;
	localparam int QW = rbst_pkg::QUOT_WIDTH;
	localparam int RW = rbst_pkg::COORD_WIDTH + 1;

	logic [QW-1:0] dvd_q [0:N];
	logic [RW-1:0] rem_q [0:N];
	logic [rbst_pkg::COORD_WIDTH-1:0] den_q [0:N];

	always_comb begin
		dvd_q[0] = {num_mag, {rbst_pkg::FRAC_BITS{1'b0}}};
		rem_q[0] = '0;
		den_q[0] = den_mag;
	end

	for (genvar i = 0; i < N; i++) begin : g_stage
		logic [RW-1:0] trial;
		logic [RW-1:0] diff;
		logic          bit_in;
		assign bit_in = dvd_q[i][QW-1];
		assign trial  = {rem_q[i][RW-2:0], bit_in};
		assign diff   = trial - {1'b0, den_q[i]};
		always_ff @(posedge clk) begin
			den_q[i+1] <= den_q[i];
			if (trial >= {1'b0, den_q[i]}) begin
				rem_q[i+1] <= diff;
				dvd_q[i+1] <= {dvd_q[i][QW-2:0], 1'b1};
			end else begin
				rem_q[i+1] <= trial;
				dvd_q[i+1] <= {dvd_q[i][QW-2:0], 1'b0};
			end
		end
	end

	assign quot = dvd_q[N];
endmodule
`default_nettype wire

// ===== sv/rbst_lane.sv =====
// One axis lane: forms the bound differences, divides both and orders near and far.
// Depends on rbst_pkg and rbst_div. Registered at the input, through the divider stages and at the slab output.
`default_nettype none
module rbst_lane (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire rbst_pkg::coord_t origin,
	input  wire rbst_pkg::coord_t dir,
	input  wire rbst_pkg::coord_t bmin,
	input  wire rbst_pkg::coord_t bmax,
	output rbst_pkg::slab_t      slab
);
	localparam int N  = rbst_pkg::DIV_STEPS;
	localparam int DW = rbst_pkg::DIFF_WIDTH;
	localparam int CW = rbst_pkg::COORD_WIDTH;

	logic signed [DW-1:0] dmin_s1, dmax_s1;
	logic [CW-1:0] dmag_s1;
	logic dneg_s1, dzero_s1, inside_s1;

	always_ff @(posedge clk) begin
		dmin_s1   <= DW'(bmin) - DW'(origin);
		dmax_s1   <= DW'(bmax) - DW'(origin);
		dneg_s1   <= dir[CW-1];
		dzero_s1  <= (dir == '0);
		dmag_s1   <= dir[CW-1] ? CW'(-dir) : CW'(dir);
		inside_s1 <= (bmin <= origin) && (origin <= bmax);
	end

	logic [DW-1:0] nmag_min, nmag_max;
	assign nmag_min = dmin_s1[DW-1] ? DW'(-dmin_s1) : DW'(dmin_s1);
	assign nmag_max = dmax_s1[DW-1] ? DW'(-dmax_s1) : DW'(dmax_s1);

	logic [rbst_pkg::QUOT_WIDTH-1:0] qmin, qmax;
	rbst_div u_div_min (.clk, .num_mag(nmag_min), .den_mag(dmag_s1), .quot(qmin));
	rbst_div u_div_max (.clk, .num_mag(nmag_max), .den_mag(dmag_s1), .quot(qmax));

	logic nsmin_d [0:N];
	logic nsmax_d [0:N];
	logic dneg_d  [0:N];
	logic dzero_d [0:N];
	logic inside_d [0:N];
	always_comb begin
		nsmin_d[0]  = dmin_s1[DW-1] ^ dneg_s1;
		nsmax_d[0]  = dmax_s1[DW-1] ^ dneg_s1;
		dneg_d[0]   = dneg_s1;
		dzero_d[0]  = dzero_s1;
		inside_d[0] = inside_s1;
	end
	for (genvar i = 0; i < N; i++) begin : g_dly
		always_ff @(posedge clk) begin
			nsmin_d[i+1]  <= nsmin_d[i];
			nsmax_d[i+1]  <= nsmax_d[i];
			dneg_d[i+1]   <= dneg_d[i];
			dzero_d[i+1]  <= dzero_d[i];
			inside_d[i+1] <= inside_d[i];
		end
	end

	rbst_pkg::tval_t tmin, tmax;
	assign tmin = nsmin_d[N] ? -rbst_pkg::tval_t'(qmin) : rbst_pkg::tval_t'(qmin);
	assign tmax = nsmax_d[N] ? -rbst_pkg::tval_t'(qmax) : rbst_pkg::tval_t'(qmax);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slab <= '0;
		end else begin
			slab.bounded <= !dzero_d[N];
			slab.miss    <= dzero_d[N] && !inside_d[N];
			slab.near_t  <= dneg_d[N] ? tmax : tmin;
			slab.far_t   <= dneg_d[N] ? tmin : tmax;
		end
	end
endmodule
`default_nettype wire

// ===== sv/rbst_merge.sv =====
// Merging stage: intersects the three axis intervals in x, y, z order over two registered steps.
// Depends on rbst_pkg.
`default_nettype none
module rbst_merge (
	input  wire logic            clk,
	input  wire rbst_pkg::slab_t sx,
	input  wire rbst_pkg::slab_t sy,
	input  wire rbst_pkg::slab_t sz,
	output logic                 hit
);
	rbst_pkg::tval_t lo_s1, hi_s1;
	logic have_s1, ok_s1;
	rbst_pkg::slab_t sz_s1;

	always_ff @(posedge clk) begin
		sz_s1 <= sz;
		ok_s1 <= !(sx.miss || sy.miss || sz.miss) &&
			!(sx.bounded && sy.bounded &&
			(sx.near_t > sy.far_t || sy.near_t > sx.far_t));
		if (sx.bounded && sy.bounded) begin
			have_s1 <= 1'b1;
			lo_s1 <= (sy.near_t > sx.near_t) ? sy.near_t : sx.near_t;
			hi_s1 <= (sx.far_t > sy.far_t) ? sy.far_t : sx.far_t;
		end else if (sx.bounded) begin
			have_s1 <= 1'b1;
			lo_s1 <= sx.near_t;
			hi_s1 <= sx.far_t;
		end else begin
			have_s1 <= sy.bounded;
			lo_s1 <= sy.near_t;
			hi_s1 <= sy.far_t;
		end
	end

	always_ff @(posedge clk) begin
		if (have_s1 && sz_s1.bounded)
			hit <= ok_s1 && !(lo_s1 > sz_s1.far_t || sz_s1.near_t > hi_s1);
		else
			hit <= ok_s1;
	end
endmodule
`default_nettype wire

// ===== verif/ray_box_slab_test_top_tb.sv =====
// Self-checking testbench for the ray versus axis-aligned box slab test.
// Drives rays and boxes, predicts each hit flag and compares it with the block's.
// Depends on rbst_pkg and ray_box_slab_test_top.
`default_nettype none
module ray_box_slab_test_top_tb;
	typedef struct {
		rbst_pkg::coord_t o[3];
		rbst_pkg::coord_t d[3];
		rbst_pkg::coord_t mn[3];
		rbst_pkg::coord_t mx[3];
	} ray_box_t;

	typedef logic signed [127:0] wide_t;

	localparam int LATENCY     = rbst_pkg::DIV_STEPS + 4;
	localparam int CYCLE_LIMIT = 200000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy, done, hit;
	rbst_pkg::coord_t origin_x = '0, origin_y = '0, origin_z = '0;
	rbst_pkg::coord_t dir_x = '0, dir_y = '0, dir_z = '0;
	rbst_pkg::coord_t box_min_x = '0, box_min_y = '0, box_min_z = '0;
	rbst_pkg::coord_t box_max_x = '0, box_max_y = '0, box_max_z = '0;

	ray_box_t pending_items[$];
	logic expected_hits[$];
	int errors = 0;
	int cycles = 0;
	int burst_left = 0;
	int gap_left = 0;
	bit hold_off = 1'b0;
	bit stim_done = 1'b0;
	bit driving = 1'b0;
	ray_box_t cur_item;

	ray_box_slab_test_top DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.origin_x(origin_x), .origin_y(origin_y), .origin_z(origin_z),
		.dir_x(dir_x), .dir_y(dir_y), .dir_z(dir_z),
		.box_min_x(box_min_x), .box_min_y(box_min_y), .box_min_z(box_min_z),
		.box_max_x(box_max_x), .box_max_y(box_max_y), .box_max_z(box_max_z),
		.done(done), .hit(hit)
	);

	always #4 clk = ~clk;

	// Exact truncating division of (num << FRAC_BITS) by den.
	function automatic wide_t slab_param(input wide_t num, input wide_t den);
		wide_t shifted;
		shifted = num <<< rbst_pkg::FRAC_BITS;
		return shifted / den;
	endfunction

	function automatic logic predict_hit(input ray_box_t it);
		wide_t lo, hi, a, b, o, d, mn, mx;
		logic have, ok;
		have = 1'b0;
		ok = 1'b1;
		lo = '0;
		hi = '0;
		for (int k = 0; k < 3; k++) begin
			if (it.d[k] == 0 && (it.mn[k] > it.o[k] || it.o[k] > it.mx[k]))
				ok = 1'b0;
		end
		for (int k = 0; k < 3; k++) begin
			o = it.o[k];
			d = it.d[k];
			mn = it.mn[k];
			mx = it.mx[k];
			if (ok && d != 0) begin
				if (d > 0) begin
					a = slab_param(mn - o, d);
					b = slab_param(mx - o, d);
				end else begin
					a = slab_param(mx - o, d);
					b = slab_param(mn - o, d);
				end
				if (!have) begin
					lo = a;
					hi = b;
					have = 1'b1;
				end else if (lo > b || a > hi) begin
					ok = 1'b0;
				end else begin
					if (a > lo) lo = a;
					if (hi > b) hi = b;
				end
			end
		end
		return ok;
	endfunction

	function automatic rbst_pkg::coord_t rand_coord();
		case ($urandom_range(0, 5))
			0: return rbst_pkg::coord_t'($urandom);
			1: return rbst_pkg::coord_t'($urandom_range(0, 3)) <<< 30
				| rbst_pkg::coord_t'($urandom_range(0, 1));
			2: return '0;
			default: return rbst_pkg::coord_t'(int'($urandom_range(0, 20 << 16)) - (10 << 16));
		endcase
	endfunction

	function automatic ray_box_t rand_item();
		ray_box_t it;
		rbst_pkg::coord_t p, q;
		for (int k = 0; k < 3; k++) begin
			it.o[k] = rand_coord();
			it.d[k] = ($urandom_range(0, 7) == 0) ? rbst_pkg::coord_t'(0) : rand_coord();
			p = rand_coord();
			q = rand_coord();
			if ($urandom_range(0, 9) != 0 && p > q) begin
				it.mn[k] = q;
				it.mx[k] = p;
			end else begin
				it.mn[k] = p;
				it.mx[k] = q;
			end
		end
		return it;
	endfunction

	function automatic ray_box_t uniform_item(input rbst_pkg::coord_t o,
			input rbst_pkg::coord_t d, input rbst_pkg::coord_t mn,
			input rbst_pkg::coord_t mx);
		ray_box_t it;
		for (int k = 0; k < 3; k++) begin
			it.o[k] = o;
			it.d[k] = d;
			it.mn[k] = mn;
			it.mx[k] = mx;
		end
		return it;
	endfunction

	initial begin
		ray_box_t it;
		rbst_pkg::coord_t cmin, cmax;
		cmin = {1'b1, {(rbst_pkg::COORD_WIDTH-1){1'b0}}};
		cmax = {1'b0, {(rbst_pkg::COORD_WIDTH-1){1'b1}}};
		pending_items.push_back(uniform_item(cmin, cmax, cmin, cmax));
		pending_items.push_back(uniform_item(cmax, cmin, cmin, cmax));
		pending_items.push_back(uniform_item(cmin, 1, cmax, cmax));
		pending_items.push_back(uniform_item(cmax, -1, cmin, cmin));
		pending_items.push_back(uniform_item(0, 0, -1, 1));
		pending_items.push_back(uniform_item(5, 0, -1, 1));
		pending_items.push_back(uniform_item(-1, -1, cmin, -1));
		pending_items.push_back(uniform_item(0, 1 << 16, 1, -1));
		pending_items.push_back(uniform_item(cmin, cmin, cmax, cmax));
		pending_items.push_back(uniform_item(-1, cmin, cmax, cmin));
		it = uniform_item(0, 1 << 16, -(1 << 16), 1 << 16);
		it.d[1] = 0;
		pending_items.push_back(it);
		it.d[1] = -(1 << 16);
		it.mn[2] = 3 << 16;
		it.mx[2] = 4 << 16;
		pending_items.push_back(it);
		it.d[0] = 0;
		it.o[0] = 2 << 16;
		pending_items.push_back(it);
		it = uniform_item(0, 1 << 16, 0, 1 << 16);
		it.mn[1] = 1 << 16;
		it.mx[1] = 2 << 16;
		pending_items.push_back(it);
		it.d[2] = -1;
		it.o[2] = cmax;
		pending_items.push_back(it);
		for (int i = 0; i < 700; i++) begin
			pending_items.push_back(rand_item());
			if (i == 350) begin
				wait (pending_items.size() == 1);
				hold_off = 1'b1;
				wait (expected_hits.size() == 0);
				hold_off = 1'b0;
			end
		end
		wait (pending_items.size() == 0 && !driving);
		stim_done = 1'b1;
	end

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
	end

	// Driver: bursts of items separated by random gaps.
	always @(negedge clk) begin
		if (arst_n) begin
			if (driving && !(start && !busy)) begin
				start <= 1'b1;
			end else if (!hold_off && pending_items.size() > 0
					&& (burst_left > 0 || gap_left == 0)) begin
				if (burst_left == 0)
					burst_left = $urandom_range(1, 30);
				burst_left--;
				if (burst_left == 0)
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				cur_item = pending_items.pop_front();
				driving = 1'b1;
				start <= 1'b1;
				origin_x <= cur_item.o[0];
				origin_y <= cur_item.o[1];
				origin_z <= cur_item.o[2];
				dir_x <= cur_item.d[0];
				dir_y <= cur_item.d[1];
				dir_z <= cur_item.d[2];
				box_min_x <= cur_item.mn[0];
				box_min_y <= cur_item.mn[1];
				box_min_z <= cur_item.mn[2];
				box_max_x <= cur_item.mx[0];
				box_max_y <= cur_item.mx[1];
				box_max_z <= cur_item.mx[2];
			end else begin
				if (gap_left > 0)
					gap_left--;
				driving = 1'b0;
				start <= 1'b0;
			end
		end
	end

	// Monitor: records accepted items and checks each result.
	always @(posedge clk) begin
		if (arst_n) begin
			cycles++;
			if (start && !busy) begin
				expected_hits.push_back(predict_hit(cur_item));
				driving = 1'b0;
			end
			if (done) begin
				if (expected_hits.size() == 0) begin
					$display("%0t: unexpected result, actual hit %0b", $time, hit);
					errors++;
				end else begin
					if (hit !== expected_hits[0]) begin
						$display("%0t: hit mismatch, expected %0b, actual %0b",
							$time, expected_hits[0], hit);
						errors++;
					end
					void'(expected_hits.pop_front());
				end
			end
			if (cycles > CYCLE_LIMIT) begin
				$display("Some tests failed");
				$finish;
			end
		end
	end

	initial begin
		wait (stim_done);
		wait (expected_hits.size() == 0);
		repeat (LATENCY + 10) @(posedge clk);
		if (errors == 0 && expected_hits.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end
endmodule
`default_nettype wire

// ===== ray_box_slab_test_top.f =====
sv/rbst_pkg.sv
sv/rbst_div.sv
sv/rbst_lane.sv
sv/rbst_merge.sv
sv/ray_box_slab_test_top.sv
verif/ray_box_slab_test_top_tb.sv
